// ===== rtl/dsc_sls_pkg.sv =====
// Shared types, constants and constant-divisor helpers for the DSC slice layout selector.
package dsc_sls_pkg;

    localparam int NUM_CAND = 8;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CLK_HIGH   = 3'd1;
    localparam logic [2:0] ST_BAD_CODE   = 3'd2;
    localparam logic [2:0] ST_ZERO_LIMIT = 3'd3;
    localparam logic [2:0] ST_NO_FIT     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_SLICE_MASK = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
    localparam logic [1:0] REG_TPUT_CODE  = 2'd2;

    // Throughput codes that the sink may not report
    localparam logic [3:0] TPUT_CODE_NONE = 4'd0;
    localparam logic [3:0] TPUT_CODE_RSVD = 4'd15;

    // Pixel clock ladder (kHz) and candidate slice counts
    localparam logic [23:0] CLK_LIMIT [NUM_CAND] = '{
        24'd340000, 24'd680000, 24'd1360000, 24'd3200000,
        24'd4800000, 24'd6400000, 24'd8000000, 24'd9600000
    };
    localparam logic [4:0] CAND [NUM_CAND] = '{
        5'd1, 5'd2, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20, 5'd24
    };

    // Slice heights
    localparam logic [6:0] HEIGHT_108 = 7'd108;
    localparam logic [6:0] HEIGHT_16  = 7'd16;
    localparam logic [6:0] HEIGHT_12  = 7'd12;
    localparam logic [6:0] HEIGHT_15  = 7'd15;

    typedef struct packed {
        logic [23:0] allowed_slice_mask;
        logic [16:0] max_slice_px;
        logic [3:0]  throughput_code;
    } sls_cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  num_slices;
        logic [15:0] slice_pixels;
    } sls_pick_t;

    // floor(x / 3) for 14-bit x: reciprocal 2^15/3 rounded up, error term 1
    function automatic logic [13:0] div3(input logic [13:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'd10923;
        return p[28:15];
    endfunction

    // floor(x / 5) for 14-bit x: reciprocal 2^16/5 rounded up
    function automatic logic [13:0] div5(input logic [13:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'd13108;
        return p[29:16];
    endfunction

    // floor(x / 27) for 14-bit x: reciprocal 2^19/27 rounded up
    function automatic logic [13:0] div27(input logic [13:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'd19419;
        return {3'b000, p[29:19]};
    endfunction

endpackage

// ===== rtl/dsc_sls_height.sv =====
// Slice height choice from the active line count.
module dsc_sls_height
    import dsc_sls_pkg::*;
(
    input  logic [15:0] v_active,
    output logic [6:0]  slice_lines
);

    logic [13:0] v_q4;
    logic [13:0] q27;
    logic [13:0] q3;
    logic        div_by_4;
    logic        div_by_108;
    logic        div_by_16;
    logic        div_by_12;

    assign v_q4     = v_active[15:2];
    assign q27      = div27(v_q4);
    assign q3       = div3(v_q4);
    assign div_by_4 = (v_active[1:0] == 2'b00);

    // 108 = 4 * 27, 12 = 4 * 3
    assign div_by_108 = div_by_4 && ((16'(q27) * 16'd27) == {2'b00, v_q4});
    assign div_by_12  = div_by_4 && ((16'(q3) * 16'd3) == {2'b00, v_q4});
    assign div_by_16  = (v_active[3:0] == 4'd0);

    always_comb
    begin
        priority if (div_by_108)
            slice_lines = HEIGHT_108;
        else if (div_by_16)
            slice_lines = HEIGHT_16;
        else if (div_by_12)
            slice_lines = HEIGHT_12;
        else
            slice_lines = HEIGHT_15;
    end

endmodule

// ===== rtl/dsc_sls_pick.sv =====
// Candidate slice count checks and first-fit selection with error priority.
module dsc_sls_pick
    import dsc_sls_pkg::*;
(
    input  logic [23:0] pixel_clock_khz,
    input  logic [15:0] h_active,
    input  logic [23:0] slice_throughput_khz,
    input  sls_cfg_t    cfg,
    output sls_pick_t   pick
);

    logic [13:0] h_q4;
    logic [13:0] h_q8;
    logic [13:0] q12;
    logic [13:0] q20;
    logic [13:0] q24;
    logic        div12;
    logic        div20;
    logic        div24;

    logic [15:0]         cand_width [NUM_CAND];
    logic [NUM_CAND-1:0] cand_div;
    logic [NUM_CAND-1:0] meets_min;
    logic [NUM_CAND-1:0] fit;

    assign h_q4 = h_active[15:2];
    assign h_q8 = {1'b0, h_active[15:3]};
    assign q12  = div3(h_q4);
    assign q20  = div5(h_q4);
    assign q24  = div3(h_q8);

    assign div12 = (h_active[1:0] == 2'b00) && ((16'(q12) * 16'd3) == {2'b00, h_q4});
    assign div20 = (h_active[1:0] == 2'b00) && ((16'(q20) * 16'd5) == {2'b00, h_q4});
    assign div24 = (h_active[2:0] == 3'b000) && ((16'(q24) * 16'd3) == {2'b00, h_q8});

    // Quotient and exact-divisibility per candidate (1,2,4,8,12,16,20,24)
    always_comb
    begin
        cand_width[0] = h_active;
        cand_width[1] = {1'b0, h_active[15:1]};
        cand_width[2] = {2'b00, h_q4};
        cand_width[3] = {2'b00, h_q8};
        cand_width[4] = {2'b00, q12};
        cand_width[5] = {4'h0, h_active[15:4]};
        cand_width[6] = {2'b00, q20};
        cand_width[7] = {2'b00, q24};

        cand_div[0] = 1'b1;
        cand_div[1] = ~h_active[0];
        cand_div[2] = (h_active[1:0] == 2'b00);
        cand_div[3] = (h_active[2:0] == 3'b000);
        cand_div[4] = div12;
        cand_div[5] = (h_active[3:0] == 4'h0);
        cand_div[6] = div20;
        cand_div[7] = div24;
    end

    // ceil(clk / c) <= tput  is the same as  clk <= tput * c
    always_comb
    begin
        for (int i = 0; i < NUM_CAND; i++)
        begin
            meets_min[i] = (pixel_clock_khz <= CLK_LIMIT[i]);
            fit[i] = meets_min[i]
                   && cfg.allowed_slice_mask[CAND[i] - 5'd1]
                   && cand_div[i]
                   && ({1'b0, cand_width[i]} < cfg.max_slice_px)
                   && ({5'd0, pixel_clock_khz}
                       <= (29'(slice_throughput_khz) * 29'(CAND[i])));
        end
    end

    always_comb
    begin
        pick.status       = ST_NO_FIT;
        pick.num_slices   = 5'd0;
        pick.slice_pixels = 16'd0;
        priority if (!meets_min[NUM_CAND-1])
            pick.status = ST_CLK_HIGH;
        else if (cfg.throughput_code == TPUT_CODE_NONE
                 || cfg.throughput_code == TPUT_CODE_RSVD)
            pick.status = ST_BAD_CODE;
        else if (cfg.max_slice_px == 17'd0 || slice_throughput_khz == 24'd0)
            pick.status = ST_ZERO_LIMIT;
        else
        begin
            for (int i = NUM_CAND - 1; i >= 0; i--)
            begin
                if (fit[i])
                begin
                    pick.status       = ST_OK;
                    pick.num_slices   = CAND[i];
                    pick.slice_pixels = cand_width[i];
                end
            end
        end
    end

endmodule

// ===== rtl/dsc_slice_layout_select_unit.sv =====
// Top level of the DSC slice layout selector: config registers, request and result registers.
//
// Usage:
//   Configuration: write allowed_slice_mask (index 0), max_slice_px (index 1) and
//   throughput_code (index 2) through cfg_valid/cfg_ready/cfg_index/cfg_data while no
//   request is in flight. cfg_ready is always high; an index of 3 is ignored.
//   Requests: drive the mode fields and pulse start. busy is always low, so a request
//   is taken on every cycle that start is high.
//   Results: result_valid is high for exactly one cycle with status, num_slices,
//   slice_pixels and slice_lines. The receiver cannot stall; results are never held.
//   Path: each accepted request passes the input register, then the result register.
//   Throughput: one request per cycle; all checks are one pass of constant-divisor
//   multiplies and compares between the two registers.
//   Reset: rst_n clears the config registers to zero and drops all valid flags.
//   With zeroed config every request reports a bad throughput code (or clock too high).
module dsc_slice_layout_select_unit
    import dsc_sls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [23:0] pixel_clock_khz,
    input  logic [15:0] h_active,
    input  logic [15:0] v_active,
    input  logic [23:0] slice_throughput_khz,

    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,

    // result strobe
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [4:0]  num_slices,
    output logic [15:0] slice_pixels,
    output logic [6:0]  slice_lines
);

    sls_cfg_t    cfg_reg;

    logic        req_valid_reg;
    logic [23:0] pclk_reg;
    logic [15:0] hact_reg;
    logic [15:0] vact_reg;
    logic [23:0] tput_reg;

    logic        res_valid_reg;
    sls_pick_t   pick_reg;
    logic [6:0]  height_reg;

    sls_pick_t   pick_next;
    logic [6:0]  height_next;
    logic        req_accept;

    // Never back-pressures: a new request enters each cycle.
    assign busy       = 1'b0;
    assign cfg_ready  = 1'b1;
    assign req_accept = start && !busy;

    // Config registers; unused index falls through untouched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SLICE_MASK: cfg_reg.allowed_slice_mask <= cfg_data;
                REG_MAX_WIDTH:  cfg_reg.max_slice_px       <= cfg_data[16:0];
                REG_TPUT_CODE:  cfg_reg.throughput_code    <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= req_accept;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            pclk_reg <= pixel_clock_khz;
            hact_reg <= h_active;
            vact_reg <= v_active;
            tput_reg <= slice_throughput_khz;
        end
    end

    // Single combinational pass
    dsc_sls_pick u_pick (
        .pixel_clock_khz      (pclk_reg),
        .h_active             (hact_reg),
        .slice_throughput_khz (tput_reg),
        .cfg                  (cfg_reg),
        .pick                 (pick_next)
    );

    dsc_sls_height u_height (
        .v_active    (vact_reg),
        .slice_lines (height_next)
    );

    // Result register: one-cycle strobe per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            pick_reg   <= pick_next;
            height_reg <= height_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = pick_reg.status;
    assign num_slices   = pick_reg.num_slices;
    assign slice_pixels = pick_reg.slice_pixels;
    assign slice_lines  = height_reg;

endmodule
